// ----- hdl/pttrs_pkg.sv -----
// Package for the pan/tilt raster scan generator.
// Holds widths, reset values, register indexes, modes and shared structs.
// No dependencies.
package pttrs_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 12;
  localparam int unsigned ANG_W   = 14;
  localparam int unsigned STEP_W  = 12;
  localparam int unsigned RANGE_W = 13;
  localparam int unsigned PRNG_W  = 12;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CIDX_W  = 4;

  localparam longint unsigned ONE_FR  = 64'd1 << ANGLE_FRAC_BITS;
  localparam longint unsigned ANG_MAX = (64'd1 << ANG_W) - 64'd1;
  localparam longint unsigned STP_MAX = (64'd1 << STEP_W) - 64'd1;

  // Rounded angles in fixed point: 0.2 rad, 2.9 rad, half a degree, pi/2.
  localparam longint unsigned LOW_RAW   = (ONE_FR * 64'd2 + 64'd5) / 64'd10;
  localparam longint unsigned HIGH_RAW  = (ONE_FR * 64'd29 + 64'd5) / 64'd10;
  localparam longint unsigned STEP_RAW  =
    (ONE_FR * 64'd8726646 + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned STARE_RAW =
    (ONE_FR * 64'd1570796327 + 64'd500000000) / 64'd1000000000;

  localparam logic [ANG_W-1:0] LIMIT_LOW_RST =
    ANG_W'((LOW_RAW > ANG_MAX) ? ANG_MAX : LOW_RAW);
  localparam logic [ANG_W-1:0] LIMIT_HIGH_RST =
    ANG_W'((HIGH_RAW > ANG_MAX) ? ANG_MAX : HIGH_RAW);
  localparam logic [STEP_W-1:0] STEP_RST =
    STEP_W'((STEP_RAW > STP_MAX) ? STP_MAX : STEP_RAW);
  localparam logic [ANG_W-1:0] STARE_RST =
    ANG_W'((STARE_RAW > ANG_MAX) ? ANG_MAX : STARE_RAW);

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_RASTER = 2'd1,
    MODE_STARE  = 2'd2
  } mode_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_SCAN_MODE  = 4'd0,
    REG_PAN_LOW    = 4'd1,
    REG_PAN_HIGH   = 4'd2,
    REG_TILT_LOW   = 4'd3,
    REG_TILT_HIGH  = 4'd4,
    REG_STEP_SIZE  = 4'd5,
    REG_STARE_PAN  = 4'd6,
    REG_STARE_TILT = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [MODE_W-1:0] scan_mode;
    logic [ANG_W-1:0]  pan_low;
    logic [ANG_W-1:0]  pan_high;
    logic [ANG_W-1:0]  tilt_low;
    logic [ANG_W-1:0]  tilt_high;
    logic [STEP_W-1:0] step_size;
    logic [ANG_W-1:0]  stare_pan;
    logic [ANG_W-1:0]  stare_tilt;
  } cfg_t;

  typedef struct packed {
    logic [ANG_W-1:0] pan_pos;
    logic [ANG_W-1:0] tilt_pos;
    logic             pan_dir_down;
    logic             tilt_dir_down;
    logic [ANG_W-1:0] last_pan;
    logic [ANG_W-1:0] last_tilt;
  } scan_state_t;

  typedef struct packed {
    mode_t             mode;
    logic [ANG_W-1:0]  point_pan;
    logic [ANG_W-1:0]  point_tilt;
    logic [PRNG_W-1:0] point_range;
  } result_t;

endpackage

// ----- hdl/pttrs_step.sv -----
// Next-state logic of the scan generator for one measurement tick.
// Raster steps pan, handles reversals and tilt stepping; stare moves to
// the stare point, forms the result. Depends on pttrs_pkg.
module pttrs_step (
  input  pttrs_pkg::cfg_t                      cfg,
  input  pttrs_pkg::scan_state_t               cur,
  input  logic [pttrs_pkg::RANGE_W-1:0]        range_cm,
  output pttrs_pkg::scan_state_t               nxt,
  output pttrs_pkg::result_t                   res,
  output logic                                 emit
);

  logic [pttrs_pkg::ANG_W:0]   pan_sum;
  logic [pttrs_pkg::ANG_W:0]   tilt_sum;
  logic [pttrs_pkg::ANG_W-1:0] pan_step;
  logic [pttrs_pkg::ANG_W-1:0] tilt_step;
  logic                        tilt_down;
  logic                        newline;
  pttrs_pkg::mode_t            mode;

  always_comb begin
    case (cfg.scan_mode)
      pttrs_pkg::MODE_RASTER: mode = pttrs_pkg::MODE_RASTER;
      pttrs_pkg::MODE_STARE:  mode = pttrs_pkg::MODE_STARE;
      default:                mode = pttrs_pkg::MODE_IDLE;
    endcase
  end

  // Saturating pan step in the current direction.
  always_comb begin
    if (cur.pan_dir_down) begin
      pan_sum  = '0;
      pan_step = (cur.pan_pos < pttrs_pkg::ANG_W'(cfg.step_size)) ? '0 :
                 cur.pan_pos - pttrs_pkg::ANG_W'(cfg.step_size);
    end else begin
      pan_sum  = {1'b0, cur.pan_pos} + (pttrs_pkg::ANG_W + 1)'(cfg.step_size);
      pan_step = pan_sum[pttrs_pkg::ANG_W] ? '1 : pan_sum[pttrs_pkg::ANG_W-1:0];
    end
  end

  always_comb begin
    if (!cur.pan_dir_down) begin
      newline = (pan_step >= cfg.pan_high);
    end else begin
      newline = (pan_step <= cfg.pan_low);
    end
  end

  // Tilt turns at its limits before its single step on a new line.
  always_comb begin
    if (cur.tilt_pos >= cfg.tilt_high) begin
      tilt_down = 1'b1;
    end else if (cur.tilt_pos <= cfg.tilt_low) begin
      tilt_down = 1'b0;
    end else begin
      tilt_down = cur.tilt_dir_down;
    end
    if (tilt_down) begin
      tilt_sum  = '0;
      tilt_step = (cur.tilt_pos < pttrs_pkg::ANG_W'(cfg.step_size)) ? '0 :
                  cur.tilt_pos - pttrs_pkg::ANG_W'(cfg.step_size);
    end else begin
      tilt_sum  = {1'b0, cur.tilt_pos} + (pttrs_pkg::ANG_W + 1)'(cfg.step_size);
      tilt_step = tilt_sum[pttrs_pkg::ANG_W] ? '1 : tilt_sum[pttrs_pkg::ANG_W-1:0];
    end
  end

  always_comb begin
    nxt = cur;
    case (mode)
      pttrs_pkg::MODE_RASTER: begin
        nxt.pan_pos  = pan_step;
        nxt.last_pan = pan_step;
        if (newline) begin
          nxt.pan_dir_down  = !cur.pan_dir_down;
          nxt.tilt_dir_down = tilt_down;
          nxt.tilt_pos      = tilt_step;
          nxt.last_tilt     = tilt_step;
        end else begin
          nxt.last_tilt = cur.tilt_pos;
        end
      end
      pttrs_pkg::MODE_STARE: begin
        nxt.pan_pos   = cfg.stare_pan;
        nxt.tilt_pos  = cfg.stare_tilt;
        nxt.last_pan  = cfg.stare_pan;
        nxt.last_tilt = cfg.stare_tilt;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  assign emit            = !range_cm[pttrs_pkg::RANGE_W-1];
  assign res.mode        = mode;
  assign res.point_pan   = nxt.last_pan;
  assign res.point_tilt  = nxt.last_tilt;
  assign res.point_range = range_cm[pttrs_pkg::PRNG_W-1:0];

endmodule

// ----- hdl/pan_tilt_raster_scan_generator_top.sv -----
// Top level of the pan/tilt raster scan generator.
// Holds the configuration and scan state registers and a two-entry output buffer.
// Depends on pttrs_pkg and pttrs_step.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_ready  | in_range_cm
//   out_    | output    | out_valid / out_ready| out_mode, out_point_pan/tilt/range
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction is taken per cycle while the skid entry is empty.
// The scan state updates in the accepting cycle from adders and comparators.
// A second output entry lets input continue while the output stalls, until it fills.
// Synchronous active-low reset restores register defaults and empties the buffer.
module pan_tilt_raster_scan_generator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pttrs_pkg::RANGE_W-1:0]     in_range_cm,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pttrs_pkg::MODE_W-1:0]      out_mode,
  output logic [pttrs_pkg::ANG_W-1:0]       out_point_pan,
  output logic [pttrs_pkg::ANG_W-1:0]       out_point_tilt,
  output logic [pttrs_pkg::PRNG_W-1:0]      out_point_range,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pttrs_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [pttrs_pkg::ANG_W-1:0]       cfg_data
);

  pttrs_pkg::cfg_t        cfg_r, cfg_nxt;
  pttrs_pkg::scan_state_t st_r, st_nxt, st_step;
  pttrs_pkg::result_t     res;
  pttrs_pkg::result_t     out_r, out_nxt, skid_r, skid_nxt;
  logic                   out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic                   emit, accept, push, pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign push      = accept && emit;
  assign pop       = out_valid_r && out_ready;

  pttrs_step u_step (
    .cfg      (cfg_r),
    .cur      (st_r),
    .range_cm (in_range_cm),
    .nxt      (st_step),
    .res      (res),
    .emit     (emit)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (pttrs_pkg::cfg_reg_t'(cfg_index))
        pttrs_pkg::REG_SCAN_MODE:  cfg_nxt.scan_mode  = cfg_data[pttrs_pkg::MODE_W-1:0];
        pttrs_pkg::REG_PAN_LOW:    cfg_nxt.pan_low    = cfg_data;
        pttrs_pkg::REG_PAN_HIGH:   cfg_nxt.pan_high   = cfg_data;
        pttrs_pkg::REG_TILT_LOW:   cfg_nxt.tilt_low   = cfg_data;
        pttrs_pkg::REG_TILT_HIGH:  cfg_nxt.tilt_high  = cfg_data;
        pttrs_pkg::REG_STEP_SIZE:  cfg_nxt.step_size  = cfg_data[pttrs_pkg::STEP_W-1:0];
        pttrs_pkg::REG_STARE_PAN:  cfg_nxt.stare_pan  = cfg_data;
        pttrs_pkg::REG_STARE_TILT: cfg_nxt.stare_tilt = cfg_data;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  assign st_nxt = accept ? st_step : st_r;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_nxt       = res;
        skid_valid_nxt = push;
      end else begin
        out_nxt       = res;
        out_valid_nxt = push;
      end
    end else if (!out_valid_r) begin
      out_nxt       = res;
      out_valid_nxt = push;
    end else if (push) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scan_mode     <= pttrs_pkg::MODE_IDLE;
      cfg_r.pan_low       <= pttrs_pkg::LIMIT_LOW_RST;
      cfg_r.pan_high      <= pttrs_pkg::LIMIT_HIGH_RST;
      cfg_r.tilt_low      <= pttrs_pkg::LIMIT_LOW_RST;
      cfg_r.tilt_high     <= pttrs_pkg::LIMIT_HIGH_RST;
      cfg_r.step_size     <= pttrs_pkg::STEP_RST;
      cfg_r.stare_pan     <= pttrs_pkg::STARE_RST;
      cfg_r.stare_tilt    <= pttrs_pkg::STARE_RST;
      st_r.pan_pos        <= pttrs_pkg::STARE_RST;
      st_r.tilt_pos       <= pttrs_pkg::STARE_RST;
      st_r.pan_dir_down   <= 1'b0;
      st_r.tilt_dir_down  <= 1'b0;
      st_r.last_pan       <= '0;
      st_r.last_tilt      <= '0;
      out_valid_r         <= 1'b0;
      skid_valid_r        <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      st_r         <= st_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_mode        = out_r.mode;
  assign out_point_pan   = out_r.point_pan;
  assign out_point_tilt  = out_r.point_tilt;
  assign out_point_range = out_r.point_range;

  // The skid entry is only ever occupied behind a full output entry.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output entry empty");

  // A failed range accepted while the output entry is empty leaves it empty.
  a_failed_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_range_cm[pttrs_pkg::RANGE_W-1] && !out_valid_r) |=> !out_valid_r)
    else $error("failed range produced a result");

  // A stare transaction moves the head to the stare point.
  a_stare_move: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cfg_r.scan_mode == pttrs_pkg::MODE_STARE) |=>
    (st_r.pan_pos == $past(cfg_r.stare_pan) && st_r.tilt_pos == $past(cfg_r.stare_tilt)))
    else $error("stare did not reach the stare point");

  // Without an accepted transaction the scan state holds.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(st_r))
    else $error("scan state changed without a transaction");

endmodule
